/* hw/rtl/hfp_pkg.sv */
// Shared types, state encodings and constants of the haptic force to PWM divider block.
package hfp_pkg;

  // Top-level sequencing of one sample.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_PEND
  } hfp_state_t;

  // Steps of the serial duty engine.
  typedef enum logic [2:0] {
    DS_IDLE,
    DS_MULP,
    DS_DIV100,
    DS_DECIDE,
    DS_MULS,
    DS_DIVS,
    DS_FINISH
  } hfp_dstate_t;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DIVIDER_M        = 3'd0;
  localparam logic [2:0] REG_DIVIDER_N        = 3'd1;
  localparam logic [2:0] REG_DIVIDER_D_BASE   = 3'd2;
  localparam logic [2:0] REG_FORCE_GAIN       = 3'd3;
  localparam logic [2:0] REG_STRENGTH_PERCENT = 3'd4;
  localparam logic [2:0] REG_MIN_STRENGTH     = 3'd5;

  // Register reset values.
  localparam logic [15:0] DIVIDER_M_RST        = 16'd1;
  localparam logic [15:0] DIVIDER_N_RST        = 16'd580;
  localparam logic [15:0] DIVIDER_D_BASE_RST   = 16'd290;
  localparam logic [15:0] FORCE_GAIN_RST       = 16'd1160;
  localparam logic [6:0]  STRENGTH_PERCENT_RST = 7'd100;
  localparam logic [15:0] MIN_STRENGTH_RST     = 16'd0;

  // Sample format checks.
  localparam logic [4:0] DEPTH_BYTE = 5'd8;
  localparam logic [4:0] DEPTH_WORD = 5'd16;
  localparam logic [7:0] COUNT_BYTE = 8'd1;
  localparam logic [7:0] COUNT_WORD = 8'd2;

  localparam logic signed [7:0] FORCE_TOP = 8'sd127;
  localparam logic [15:0] PERCENT_DIV = 16'd100;

  // Last value of the step counter in each serial phase.
  localparam logic [4:0] MULP_LAST = 5'd7;
  localparam logic [4:0] MULS_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST  = 5'd16;

  typedef struct packed {
    logic [15:0] divider_n;
    logic [15:0] min_strength;
    logic [15:0] divider_d_base;
    logic [15:0] force_gain;
    logic [6:0]  strength_percent;
  } hfp_cfg_t;

  typedef struct packed {
    logic        done;
    logic [15:0] duty;
  } hfp_duty_t;

  // Packed so that status lands in the lowest bit of the result data.
  typedef struct packed {
    logic [15:0] n_word;
    logic [15:0] d_word;
    logic [15:0] m_word;
    logic        regs_written;
    logic        clock_on;
    logic        amp_on;
    logic        status;
  } hfp_result_t;

endpackage

/* hw/rtl/hfp_duty.sv */
// Serial duty engine: shift-add multipliers and a shared restoring divider.
module hfp_duty (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [7:0]     frc_in,
  input  hfp_pkg::hfp_cfg_t     cfg,
  output hfp_pkg::hfp_duty_t    res
);

  hfp_pkg::hfp_dstate_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        pos_r, pos_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] pa_r, pa_nxt;
  logic [7:0]  pl_r, pl_nxt;
  logic [16:0] ma_r, ma_nxt;
  logic [15:0] ml_r, ml_nxt;
  logic [16:0] mc_r, mc_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] dq_r, dq_nxt;
  logic [15:0] dv_r, dv_nxt;
  logic        qneg_r, qneg_nxt;
  logic [15:0] duty_r, duty_nxt;

  logic [16:0] psum;
  logic [17:0] msum;
  logic [16:0] ma_step;
  logic [15:0] ml_step;
  logic [16:0] trial;
  logic [17:0] diff;
  logic        ge;
  logic [15:0] rem_step;
  logic [16:0] dq_step;
  logic [16:0] q_signed;
  logic [7:0]  frc_mag;

  logic [19:0]        fmag;
  logic signed [19:0] n_s, mn_s, s_s, fd_s, tp_s, tn_s, tnc_s, sm_s, smag_s, tm_s;
  logic               sat;

  // One step of each shift-add multiplier: add, then shift the pair right.
  assign psum    = {1'b0, pa_r} + (pl_r[0] ? {1'b0, cfg.force_gain} : 17'd0);
  assign msum    = {1'b0, ma_r} + (ml_r[0] ? {1'b0, mc_r} : 18'd0);
  assign ma_step = msum[17:1];
  assign ml_step = {msum[0], ml_r[15:1]};

  // One restoring division step; quotient bits enter at the bottom of dq.
  assign trial    = {rem_r, dq_r[16]};
  assign diff     = {1'b0, trial} - {2'b00, dv_r};
  assign ge       = ~diff[17];
  assign rem_step = ge ? diff[15:0] : trial[15:0];
  assign dq_step  = {dq_r[15:0], ge};
  assign q_signed = qneg_r ? (17'd0 - dq_step) : dq_step;

  assign frc_mag = frc_in[7] ? (8'd0 - frc_in) : frc_in;

  // Decision arithmetic once the force product and scaled N are known.
  always_comb begin
    n_s    = $signed({4'b0000, cfg.divider_n});
    mn_s   = $signed({4'b0000, cfg.min_strength});
    s_s    = $signed({3'b000, dq_r});
    fmag   = {4'b0000, pa_r} + {19'd0, |pl_r};
    // Floor of a negative product over 256 rounds its magnitude up.
    fd_s   = neg_r ? -$signed(fmag) : $signed({4'b0000, pa_r});
    tp_s   = n_s - $signed({4'b0000, pa_r});
    tn_s   = fd_s + $signed({4'b0000, cfg.divider_d_base});
    tnc_s  = ((n_s - tn_s) > s_s) ? (n_s - s_s) : tn_s;
    sat    = (tp_s < mn_s) || (cfg.divider_n == cfg.min_strength);
    sm_s   = s_s - mn_s;
    smag_s = sm_s[19] ? -sm_s : sm_s;
    tm_s   = tp_s - mn_s;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hfp_pkg::DS_IDLE: begin
        if (start) state_nxt = hfp_pkg::DS_MULP;
      end
      hfp_pkg::DS_MULP: begin
        if (cnt_r == hfp_pkg::MULP_LAST) state_nxt = hfp_pkg::DS_DIV100;
      end
      hfp_pkg::DS_DIV100: begin
        if (cnt_r == hfp_pkg::DIV_LAST) state_nxt = hfp_pkg::DS_DECIDE;
      end
      hfp_pkg::DS_DECIDE: begin
        if (pos_r && !sat) state_nxt = hfp_pkg::DS_MULS;
        else state_nxt = hfp_pkg::DS_FINISH;
      end
      hfp_pkg::DS_MULS: begin
        if (cnt_r == hfp_pkg::MULS_LAST) state_nxt = hfp_pkg::DS_DIVS;
      end
      hfp_pkg::DS_DIVS: begin
        if (cnt_r == hfp_pkg::DIV_LAST) state_nxt = hfp_pkg::DS_FINISH;
      end
      hfp_pkg::DS_FINISH: begin
        state_nxt = hfp_pkg::DS_IDLE;
      end
      default: begin
        state_nxt = hfp_pkg::DS_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    neg_nxt  = neg_r;
    pa_nxt   = pa_r;
    pl_nxt   = pl_r;
    ma_nxt   = ma_r;
    ml_nxt   = ml_r;
    mc_nxt   = mc_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dv_nxt   = dv_r;
    qneg_nxt = qneg_r;
    duty_nxt = duty_r;
    case (state_r)
      hfp_pkg::DS_IDLE: begin
        if (start) begin
          pos_nxt = (frc_in > 8'sd0);
          neg_nxt = frc_in[7];
          pa_nxt  = 16'd0;
          pl_nxt  = frc_mag;
          ma_nxt  = 17'd0;
          ml_nxt  = {9'd0, cfg.strength_percent};
          mc_nxt  = {1'b0, cfg.divider_n};
          cnt_nxt = 5'd0;
        end
      end
      hfp_pkg::DS_MULP: begin
        pa_nxt = psum[16:1];
        pl_nxt = {psum[0], pl_r[7:1]};
        ma_nxt = ma_step;
        ml_nxt = ml_step;
        if (cnt_r == hfp_pkg::MULP_LAST) begin
          // N times strength sits in {ma, ml[15:8]}; it is below 2^17 * 100.
          cnt_nxt = 5'd0;
          rem_nxt = {8'd0, ma_step[16:9]};
          dq_nxt  = {ma_step[8:0], ml_step[15:8]};
          dv_nxt  = hfp_pkg::PERCENT_DIV;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      hfp_pkg::DS_DIV100, hfp_pkg::DS_DIVS: begin
        rem_nxt = rem_step;
        dq_nxt  = dq_step;
        if (cnt_r == hfp_pkg::DIV_LAST) begin
          cnt_nxt = 5'd0;
          if (state_r == hfp_pkg::DS_DIVS) duty_nxt = q_signed[15:0] + cfg.min_strength;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      hfp_pkg::DS_DECIDE: begin
        if (!pos_r) begin
          duty_nxt = tnc_s[15:0];
        end else if (sat) begin
          duty_nxt = cfg.min_strength;
        end else begin
          ma_nxt   = 17'd0;
          ml_nxt   = tm_s[15:0];
          mc_nxt   = smag_s[16:0];
          qneg_nxt = sm_s[19];
          dv_nxt   = cfg.divider_n - cfg.min_strength;
          cnt_nxt  = 5'd0;
        end
      end
      hfp_pkg::DS_MULS: begin
        ma_nxt = ma_step;
        ml_nxt = ml_step;
        if (cnt_r == hfp_pkg::MULS_LAST) begin
          // The 33-bit product is below divisor * 2^17, so 17 steps suffice.
          cnt_nxt = 5'd0;
          rem_nxt = ma_step[16:1];
          dq_nxt  = {ma_step[0], ml_step};
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_comb begin
    res.done = (state_r == hfp_pkg::DS_FINISH);
    res.duty = duty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hfp_pkg::DS_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    neg_r  <= neg_nxt;
    pa_r   <= pa_nxt;
    pl_r   <= pl_nxt;
    ma_r   <= ma_nxt;
    ml_r   <= ml_nxt;
    mc_r   <= mc_nxt;
    rem_r  <= rem_nxt;
    dq_r   <= dq_nxt;
    dv_r   <= dv_nxt;
    qneg_r <= qneg_nxt;
    duty_r <= duty_nxt;
  end

endmodule

/* hw/rtl/haptic_force_to_pwm_mnd.sv */
// A rejected, zero or unchanged sample goes from its transfer straight to the pending state;
// a sample needing new words first runs through the serial engine: an 8-step shift-add
// multiply, a 17-step restoring divide by 100, and, for a positive mirrored force that does
// not saturate, a 16-step multiply and a second 17-step divide.
// One sample is in work at a time; a new one is taken while the previous result waits.
// Reset (synchronous, active low) restores the register defaults and turns amplifier and clock off.
module haptic_force_to_pwm_mnd #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_value[15:0], bit_depth[20:16], byte_count[28:21]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status[0], amp_on[1], clock_on[2], regs_written[3],
                                  // m_word[19:4], d_word[35:20], n_word[51:36]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int OUT_BITS = (COUNTER_WIDTH < 16) ? COUNTER_WIDTH : 16;
  localparam logic [15:0] WORD_MASK = 16'((64'd1 << OUT_BITS) - 64'd1);

  logic [15:0] div_m_r, div_m_nxt;
  logic [15:0] div_n_r, div_n_nxt;
  logic [15:0] div_d_r, div_d_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic [6:0]  pct_r, pct_nxt;
  logic [15:0] min_r, min_nxt;

  hfp_pkg::hfp_state_t  state_r, state_nxt;
  logic                 amp_r, amp_nxt;
  logic                 clk_on_r, clk_on_nxt;
  logic signed [7:0]    prev_r, prev_nxt;
  hfp_pkg::hfp_result_t res_r, res_nxt;
  hfp_pkg::hfp_result_t out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  hfp_pkg::hfp_cfg_t    eng_cfg;
  hfp_pkg::hfp_duty_t   eng_res;
  logic                 eng_start;
  logic                 load_out;
  logic                 slot_free;
  logic                 in_fire;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;

  logic [15:0]       sample;
  logic [4:0]        depth;
  logic [7:0]        count;
  logic              ok8, ok16, bad;
  logic signed [7:0] frc, refl;
  logic              raw_zero, need_calc;

  assign sample = in_tdata[15:0];
  assign depth  = in_tdata[20:16];
  assign count  = in_tdata[28:21];

  assign ok8      = (depth == hfp_pkg::DEPTH_BYTE) && (count == hfp_pkg::COUNT_BYTE);
  assign ok16     = (depth == hfp_pkg::DEPTH_WORD) && (count == hfp_pkg::COUNT_WORD);
  assign bad      = !ok8 && !ok16;
  assign frc      = ok16 ? sample[15:8] : sample[7:0];
  assign raw_zero = (frc == 8'sd0);
  // A positive force is mirrored so that full force gives the shortest duty.
  assign refl      = (frc > 8'sd0) ? (hfp_pkg::FORCE_TOP - frc) : frc;
  assign need_calc = !bad && !raw_zero && (refl != prev_r);

  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:2];

  always_comb begin
    eng_cfg.divider_n        = div_n_r;
    eng_cfg.min_strength     = min_r;
    eng_cfg.divider_d_base   = div_d_r;
    eng_cfg.force_gain       = gain_r;
    eng_cfg.strength_percent = pct_r;
  end

  hfp_duty u_duty (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (eng_start),
    .frc_in (refl),
    .cfg    (eng_cfg),
    .res    (eng_res)
  );

  // Register file.
  always_comb begin
    div_m_nxt = div_m_r;
    div_n_nxt = div_n_r;
    div_d_nxt = div_d_r;
    gain_nxt  = gain_r;
    pct_nxt   = pct_r;
    min_nxt   = min_r;
    if (cfg_wr) begin
      case (cfg_idx)
        hfp_pkg::REG_DIVIDER_M:        div_m_nxt = cfg_pwdata[15:0];
        hfp_pkg::REG_DIVIDER_N:        div_n_nxt = cfg_pwdata[15:0];
        hfp_pkg::REG_DIVIDER_D_BASE:   div_d_nxt = cfg_pwdata[15:0];
        hfp_pkg::REG_FORCE_GAIN:       gain_nxt  = cfg_pwdata[15:0];
        hfp_pkg::REG_STRENGTH_PERCENT: pct_nxt   = cfg_pwdata[6:0];
        hfp_pkg::REG_MIN_STRENGTH:     min_nxt   = cfg_pwdata[15:0];
        default:                       div_m_nxt = div_m_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hfp_pkg::REG_DIVIDER_M:        cfg_prdata = {16'd0, div_m_r};
      hfp_pkg::REG_DIVIDER_N:        cfg_prdata = {16'd0, div_n_r};
      hfp_pkg::REG_DIVIDER_D_BASE:   cfg_prdata = {16'd0, div_d_r};
      hfp_pkg::REG_FORCE_GAIN:       cfg_prdata = {16'd0, gain_r};
      hfp_pkg::REG_STRENGTH_PERCENT: cfg_prdata = {25'd0, pct_r};
      hfp_pkg::REG_MIN_STRENGTH:     cfg_prdata = {16'd0, min_r};
      default:                       cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hfp_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = need_calc ? hfp_pkg::ST_CALC : hfp_pkg::ST_PEND;
      end
      hfp_pkg::ST_CALC: begin
        if (eng_res.done) state_nxt = hfp_pkg::ST_PEND;
      end
      hfp_pkg::ST_PEND: begin
        if (slot_free) state_nxt = hfp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hfp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready = (state_r == hfp_pkg::ST_IDLE);
    eng_start = in_fire && need_calc;
    load_out  = (state_r == hfp_pkg::ST_PEND) && slot_free;
  end

  // Held state and the result path.
  always_comb begin
    amp_nxt       = amp_r;
    clk_on_nxt    = clk_on_r;
    prev_nxt      = prev_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (in_fire) begin
      if (!bad && raw_zero) begin
        amp_nxt    = 1'b0;
        clk_on_nxt = 1'b0;
        prev_nxt   = 8'sd0;
      end else if (need_calc) begin
        amp_nxt    = 1'b1;
        clk_on_nxt = 1'b1;
        prev_nxt   = refl;
      end
      res_nxt.status       = bad;
      res_nxt.amp_on       = amp_nxt;
      res_nxt.clock_on     = clk_on_nxt;
      res_nxt.regs_written = 1'b0;
      res_nxt.m_word       = 16'd0;
      res_nxt.d_word       = 16'd0;
      res_nxt.n_word       = 16'd0;
    end

    if ((state_r == hfp_pkg::ST_CALC) && eng_res.done) begin
      res_nxt.regs_written = 1'b1;
      res_nxt.m_word       = div_m_r & WORD_MASK;
      res_nxt.d_word       = ~{eng_res.duty[14:0], 1'b0} & WORD_MASK;
      res_nxt.n_word       = ~(div_n_r - div_m_r) & WORD_MASK;
    end

    if (load_out) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hfp_pkg::ST_IDLE;
      amp_r       <= 1'b0;
      clk_on_r    <= 1'b0;
      prev_r      <= 8'sd0;
      out_valid_r <= 1'b0;
      div_m_r     <= hfp_pkg::DIVIDER_M_RST;
      div_n_r     <= hfp_pkg::DIVIDER_N_RST;
      div_d_r     <= hfp_pkg::DIVIDER_D_BASE_RST;
      gain_r      <= hfp_pkg::FORCE_GAIN_RST;
      pct_r       <= hfp_pkg::STRENGTH_PERCENT_RST;
      min_r       <= hfp_pkg::MIN_STRENGTH_RST;
    end else begin
      state_r     <= state_nxt;
      amp_r       <= amp_nxt;
      clk_on_r    <= clk_on_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
      div_m_r     <= div_m_nxt;
      div_n_r     <= div_n_nxt;
      div_d_r     <= div_d_nxt;
      gain_r      <= gain_nxt;
      pct_r       <= pct_nxt;
      min_r       <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTH
  a_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.regs_written |->
      out_r.m_word == 16'd0 && out_r.d_word == 16'd0 && out_r.n_word == 16'd0)
    else $error("divider words not cleared on a result without a write");

  a_fail_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status |-> !out_r.regs_written)
    else $error("failed sample reports written divider words");

  a_write_enables: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.regs_written |-> out_r.amp_on && out_r.clock_on)
    else $error("written divider words without amplifier and clock on");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    eng_res.done |-> state_r == hfp_pkg::ST_CALC)
    else $error("duty engine finished outside the calculation state");

  a_start_calc: assert property (@(posedge clk) disable iff (!rst_n)
    eng_start |=> state_r == hfp_pkg::ST_CALC)
    else $error("duty engine started without entering the calculation state");
`endif

endmodule
